/* rtl/core/nls_pkg.sv */
// ----------------------------------------------------------------------------
// nls_pkg
// shared constants, codes and the reciprocal table of the log series block
// ----------------------------------------------------------------------------
package nls_pkg;

    localparam int TERMS      = 20;
    localparam int TABLE_MAX  = 32;
    localparam int TERM_LIMIT = (TERMS > TABLE_MAX) ? TABLE_MAX : TERMS;

    localparam int X_W    = 48;
    localparam int MAG_W  = 33;
    localparam int REM_W  = 34;
    localparam int SUM_W  = 38;
    localparam int CNT_W  = 4;
    localparam int IDX_W  = 6;
    localparam int OUT_W  = 21;
    localparam int HALF_W = X_W / 2;
    localparam int ACC_W  = 2 * X_W;
    localparam int FIX_W  = 36;

    localparam logic [MAG_W-1:0] Q_ONE = 33'h1_0000_0000;
    localparam logic [X_W-1:0]   Q_TWO = 48'h2_0000_0000;
    localparam logic [REM_W-1:0] E_Q32 = 34'd11674931554;

    // floor(2^(X_W+32) / E_Q32), about 2^X_W / e, the quotient estimate is at most one low
    localparam logic [X_W+32:0]  E_SCALE = {1'b1, {(X_W + 32){1'b0}}};
    localparam logic [X_W-1:0]   E_RECIP = X_W'(E_SCALE / E_Q32);

    typedef logic [1:0] t_status;
    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_NAN     = 2'd1;
    localparam t_status ST_NEG_INF = 2'd2;

    localparam logic [OUT_W-1:0] LOG_MIN = 21'h10_0000;
    localparam logic [OUT_W-1:0] LOG_MAX = 21'h0F_FFFF;

    localparam logic [MAG_W-1:0] RECIP_TAB [0:TABLE_MAX] = '{
        33'd0,
        Q_ONE / 1,  Q_ONE / 2,  Q_ONE / 3,  Q_ONE / 4,
        Q_ONE / 5,  Q_ONE / 6,  Q_ONE / 7,  Q_ONE / 8,
        Q_ONE / 9,  Q_ONE / 10, Q_ONE / 11, Q_ONE / 12,
        Q_ONE / 13, Q_ONE / 14, Q_ONE / 15, Q_ONE / 16,
        Q_ONE / 17, Q_ONE / 18, Q_ONE / 19, Q_ONE / 20,
        Q_ONE / 21, Q_ONE / 22, Q_ONE / 23, Q_ONE / 24,
        Q_ONE / 25, Q_ONE / 26, Q_ONE / 27, Q_ONE / 28,
        Q_ONE / 29, Q_ONE / 30, Q_ONE / 31, Q_ONE / 32
    };

endpackage

/* rtl/core/nls_div_e.sv */
// ----------------------------------------------------------------------------
// nls_div_e
// division by the constant e through a reciprocal product on one 24x24
// multiplier, then one compare and correct step, one quotient at a time
// ----------------------------------------------------------------------------
module nls_div_e (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [nls_pkg::X_W-1:0]     i_dividend,
    output logic                        o_done,
    output logic [nls_pkg::X_W-1:0]     o_quotient
);

    typedef enum logic [3:0] {
        D_IDLE,
        D_RLO_ALO,
        D_RLO_AHI,
        D_RHI_ALO,
        D_RHI_AHI,
        D_ELO_QLO,
        D_ELO_QHI,
        D_EHI_QLO,
        D_FIX
    } t_dstate;

    t_dstate                        r_state, n_state;
    logic                           r_done, n_done;
    logic [nls_pkg::X_W-1:0]        r_a, n_a;
    logic [nls_pkg::ACC_W-1:0]      r_acc, n_acc;
    logic [nls_pkg::X_W-1:0]        r_quot, n_quot;
    logic [nls_pkg::HALF_W-1:0]     mul_x, mul_y;
    logic [nls_pkg::X_W-1:0]        pp;
    logic [nls_pkg::FIX_W-1:0]      rem;

    assign pp  = nls_pkg::X_W'(mul_x) * nls_pkg::X_W'(mul_y);
    // dividend * 2^32 minus estimate * e, exact in the low bits
    assign rem = {r_a[nls_pkg::FIX_W-33:0], 32'd0} - r_acc[nls_pkg::FIX_W-1:0];

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_a     = r_a;
        n_acc   = r_acc;
        n_quot  = r_quot;
        mul_x   = '0;
        mul_y   = '0;
        case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    n_a     = i_dividend;
                    n_acc   = '0;
                    n_state = D_RLO_ALO;
                end
            end
            D_RLO_ALO: begin
                mul_x   = r_a[nls_pkg::HALF_W-1:0];
                mul_y   = nls_pkg::E_RECIP[nls_pkg::HALF_W-1:0];
                n_acc   = r_acc + nls_pkg::ACC_W'(pp);
                n_state = D_RLO_AHI;
            end
            D_RLO_AHI: begin
                mul_x   = r_a[nls_pkg::X_W-1:nls_pkg::HALF_W];
                mul_y   = nls_pkg::E_RECIP[nls_pkg::HALF_W-1:0];
                n_acc   = r_acc + (nls_pkg::ACC_W'(pp) << nls_pkg::HALF_W);
                n_state = D_RHI_ALO;
            end
            D_RHI_ALO: begin
                mul_x   = r_a[nls_pkg::HALF_W-1:0];
                mul_y   = nls_pkg::E_RECIP[nls_pkg::X_W-1:nls_pkg::HALF_W];
                n_acc   = r_acc + (nls_pkg::ACC_W'(pp) << nls_pkg::HALF_W);
                n_state = D_RHI_AHI;
            end
            D_RHI_AHI: begin
                mul_x   = r_a[nls_pkg::X_W-1:nls_pkg::HALF_W];
                mul_y   = nls_pkg::E_RECIP[nls_pkg::X_W-1:nls_pkg::HALF_W];
                n_acc   = r_acc + (nls_pkg::ACC_W'(pp) << nls_pkg::X_W);
                n_state = D_ELO_QLO;
            end
            D_ELO_QLO: begin
                // quotient estimate is the high half of the product
                mul_x   = r_acc[nls_pkg::X_W+nls_pkg::HALF_W-1:nls_pkg::X_W];
                mul_y   = nls_pkg::E_Q32[nls_pkg::HALF_W-1:0];
                n_quot  = r_acc[nls_pkg::ACC_W-1:nls_pkg::X_W];
                n_acc   = nls_pkg::ACC_W'(pp);
                n_state = D_ELO_QHI;
            end
            D_ELO_QHI: begin
                mul_x   = nls_pkg::HALF_W'(r_quot[nls_pkg::FIX_W-1:nls_pkg::HALF_W]);
                mul_y   = nls_pkg::E_Q32[nls_pkg::HALF_W-1:0];
                n_acc   = r_acc + (nls_pkg::ACC_W'(pp) << nls_pkg::HALF_W);
                n_state = D_EHI_QLO;
            end
            D_EHI_QLO: begin
                mul_x   = r_quot[nls_pkg::HALF_W-1:0];
                mul_y   = nls_pkg::HALF_W'(nls_pkg::E_Q32[nls_pkg::REM_W-1:nls_pkg::HALF_W]);
                n_acc   = r_acc + (nls_pkg::ACC_W'(pp) << nls_pkg::HALF_W);
                n_state = D_FIX;
            end
            D_FIX: begin
                if (rem >= nls_pkg::FIX_W'(nls_pkg::E_Q32)) begin
                    n_quot = r_quot + 1'b1;
                end
                n_done  = 1'b1;
                n_state = D_IDLE;
            end
            default: begin
                n_state = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_a    <= n_a;
        r_acc  <= n_acc;
        r_quot <= n_quot;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quot;

endmodule

/* rtl/core/nls_mulq.sv */
// ----------------------------------------------------------------------------
// nls_mulq
// shared q32 magnitude multiplier, truncated high part, registered product
// ----------------------------------------------------------------------------
module nls_mulq (
    input  logic                        i_clk,
    input  logic [nls_pkg::MAG_W-1:0]   i_op_a,
    input  logic [nls_pkg::MAG_W-1:0]   i_op_b,
    output logic [nls_pkg::MAG_W-1:0]   o_prod
);

    logic [63:0]                full;
    logic [nls_pkg::MAG_W-1:0]  n_prod;
    logic [nls_pkg::MAG_W-1:0]  r_prod;

    assign full = 64'(i_op_a[31:0]) * 64'(i_op_b[31:0]);

    always_comb begin
        // an operand of one or more passes the other through
        if (i_op_a[32]) begin
            n_prod = i_op_b;
        end else if (i_op_b[32]) begin
            n_prod = i_op_a;
        end else begin
            n_prod = {1'b0, full[63:32]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

/* rtl/core/natural_log_series.sv */
// ----------------------------------------------------------------------------
// natural_log_series
// natural log of a signed q16.16 operand: range reduction by e, then an
// alternating series in (x-1) on one shared multiplier
// ----------------------------------------------------------------------------
// channel | dir | handshake                   | payload
// in      | in  | i_in_valid / o_in_ready     | i_x_value
// out     | out | o_out_valid / i_out_ready   | o_log_value, o_status
//
// negative or zero operand: result valid in the cycle after the beat
// positive operand: k divisions by e (k <= 10), then TERMS series terms;
// each division runs the reciprocal divider and returns through S_REDUCE,
// each term steps through S_PW, S_TERM and S_ACC
// one operand at a time; o_in_ready is low until the result beat is taken
// synchronous active-low reset returns the sequencer to idle
// ----------------------------------------------------------------------------
module natural_log_series (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic signed [31:0]  i_x_value,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [20:0]  o_log_value,
    output logic [1:0]          o_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_DIV,
        S_PW,
        S_TERM,
        S_ACC,
        S_FINAL,
        S_OUT
    } t_state;

    t_state                         r_state, n_state;
    logic [nls_pkg::X_W-1:0]        r_x, n_x;
    logic [nls_pkg::CNT_W-1:0]      r_count, n_count;
    logic                           r_tneg, n_tneg;
    logic [nls_pkg::MAG_W-1:0]      r_tmag, n_tmag;
    logic [nls_pkg::MAG_W-1:0]      r_pw, n_pw;
    logic [nls_pkg::IDX_W-1:0]      r_idx, n_idx;
    logic signed [nls_pkg::SUM_W-1:0] r_sum, n_sum;
    logic [nls_pkg::OUT_W-1:0]      r_log, n_log;
    nls_pkg::t_status               r_status, n_status;

    logic                           div_start;
    logic                           div_done;
    logic [nls_pkg::X_W-1:0]        div_quot;
    logic [nls_pkg::MAG_W-1:0]      mul_a, mul_b, mul_prod;
    logic [nls_pkg::MAG_W:0]        tdiff;
    logic signed [nls_pkg::SUM_W-1:0] term_s;
    logic signed [39:0]             total;
    logic [23:0]                    res;

    assign div_start = (r_state == S_REDUCE) && (r_x > nls_pkg::Q_TWO);

    nls_div_e u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_x),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    assign mul_a = (r_state == S_TERM) ? mul_prod : r_pw;
    assign mul_b = (r_state == S_TERM) ? nls_pkg::RECIP_TAB[r_idx] : r_tmag;

    nls_mulq u_mul (
        .i_clk  (i_clk),
        .i_op_a (mul_a),
        .i_op_b (mul_b),
        .o_prod (mul_prod)
    );

    assign tdiff  = (r_x[nls_pkg::MAG_W:0] < {1'b0, nls_pkg::Q_ONE})
                  ? ({1'b0, nls_pkg::Q_ONE} - r_x[nls_pkg::MAG_W:0])
                  : (r_x[nls_pkg::MAG_W:0] - {1'b0, nls_pkg::Q_ONE});
    assign term_s = $signed({5'd0, mul_prod});
    assign total  = $signed({4'd0, r_count, 32'd0}) + 40'(r_sum);
    assign res    = total[39:16];

    always_comb begin
        n_state  = r_state;
        n_x      = r_x;
        n_count  = r_count;
        n_tneg   = r_tneg;
        n_tmag   = r_tmag;
        n_pw     = r_pw;
        n_idx    = r_idx;
        n_sum    = r_sum;
        n_log    = r_log;
        n_status = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_x_value[31]) begin
                        n_log    = '0;
                        n_status = nls_pkg::ST_NAN;
                        n_state  = S_OUT;
                    end else if (i_x_value == '0) begin
                        n_log    = nls_pkg::LOG_MIN;
                        n_status = nls_pkg::ST_NEG_INF;
                        n_state  = S_OUT;
                    end else begin
                        n_x     = {i_x_value[31:0], 16'd0};
                        n_count = '0;
                        n_state = S_REDUCE;
                    end
                end
            end
            S_REDUCE: begin
                if (r_x > nls_pkg::Q_TWO) begin
                    n_state = S_DIV;
                end else begin
                    n_tneg  = r_x[nls_pkg::MAG_W:0] < {1'b0, nls_pkg::Q_ONE};
                    n_tmag  = tdiff[nls_pkg::MAG_W-1:0];
                    n_pw    = nls_pkg::Q_ONE;
                    n_idx   = nls_pkg::IDX_W'(1);
                    n_sum   = '0;
                    n_state = S_PW;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_x     = div_quot;
                    n_count = r_count + 1'b1;
                    n_state = S_REDUCE;
                end
            end
            S_PW: begin
                n_state = S_TERM;
            end
            S_TERM: begin
                n_pw    = mul_prod;
                n_state = S_ACC;
            end
            S_ACC: begin
                // even terms subtract, odd terms follow the sign of t
                if (!r_idx[0] || r_tneg) begin
                    n_sum = r_sum - term_s;
                end else begin
                    n_sum = r_sum + term_s;
                end
                if (r_idx == nls_pkg::IDX_W'(nls_pkg::TERM_LIMIT)) begin
                    n_state = S_FINAL;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_PW;
                end
            end
            S_FINAL: begin
                if (res[23:20] == {4{res[20]}}) begin
                    n_log = res[nls_pkg::OUT_W-1:0];
                end else if (res[23]) begin
                    n_log = nls_pkg::LOG_MIN;
                end else begin
                    n_log = nls_pkg::LOG_MAX;
                end
                n_status = nls_pkg::ST_OK;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_x      <= n_x;
        r_count  <= n_count;
        r_tneg   <= n_tneg;
        r_tmag   <= n_tmag;
        r_pw     <= n_pw;
        r_idx    <= n_idx;
        r_sum    <= n_sum;
        r_log    <= n_log;
        r_status <= n_status;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_log_value = $signed(r_log);
    assign o_status    = r_status;

endmodule

/* rtl/core/nls_checker.sv */
// ----------------------------------------------------------------------------
// nls_checker
// port-level checks of the log series block, bound to the top level
// ----------------------------------------------------------------------------
module nls_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_ready,
    input  logic signed [31:0]  i_x_value,
    input  logic                o_out_valid,
    input  logic                i_out_ready,
    input  logic signed [20:0]  o_log_value,
    input  logic [1:0]          o_status
);

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while an operand is in work");

    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while a result beat is pending");

    a_nan_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == nls_pkg::ST_NAN)) |-> (o_log_value == '0))
        else $error("not-a-number result with nonzero value");

    a_neg_inf_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == nls_pkg::ST_NEG_INF))
            |-> (o_log_value == $signed(nls_pkg::LOG_MIN)))
        else $error("minus-infinity result not at the most negative value");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready)
            |=> (o_out_valid && $stable(o_log_value) && $stable(o_status)))
        else $error("stalled result beat changed");

endmodule

bind natural_log_series nls_checker u_nls_checker (.*);

/* bench/natural_log_series_test.sv */
// ----------------------------------------------------------------------------
// natural_log_series_test
// Drives q16.16 operands into the natural log block with a bursty sender and
// a randomly stalling receiver. Each operand taken by the block is run
// through an independent bit-exact model of the range reduction by e and the
// alternating series. The model's result is queued, and every result beat is
// compared field by field against the oldest queued entry.
// ----------------------------------------------------------------------------
module natural_log_series_test;

    timeunit 1ns;
    timeprecision 1ps;

    import nls_pkg::*;

    localparam int          CLK_PERIOD   = 10;
    localparam int          RESET_CYCLES = 4;
    localparam int          RANDOM_OPS   = 1000;
    localparam int          SETTLE_CYCLES = 50;
    localparam int          MAX_REPORTS  = 10;
    localparam longint      CYCLE_LIMIT  = 3_000_000;

    localparam logic [63:0] ONE_Q32 = 64'h1_0000_0000;
    localparam logic [63:0] TWO_Q32 = 64'h2_0000_0000;
    localparam logic [63:0] E_FIX   = 64'd11674931554;
    localparam int          N_TERMS = (TERMS > 32) ? 32 : TERMS;

    typedef struct packed {
        logic signed [31:0] operand;
        logic               hold;
    } x_beat_t;

    typedef struct packed {
        logic signed [31:0] operand;
        logic signed [20:0] log_value;
        t_status            status;
    } ln_result_t;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    logic signed [31:0] i_x_value   = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [20:0] o_log_value;
    logic [1:0]         o_status;

    x_beat_t    x_pending [$];
    ln_result_t ln_expected [$];

    int     mismatches = 0;
    int     burst_left = 0;
    int     gap_left   = 0;
    int     ready_pct  = 100;
    int     mode_left  = 0;
    longint cycle_cnt  = 0;

    natural_log_series u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_x_value   (i_x_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_log_value (o_log_value),
        .o_status    (o_status)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // truncating q32 product, a full-scale factor passes the other through
    function automatic logic [63:0] mul_frac(logic [63:0] a, logic [63:0] b);
        if (a >= ONE_Q32) begin
            return b;
        end
        if (b >= ONE_Q32) begin
            return a;
        end
        return (a * b) >> 32;
    endfunction

    function automatic ln_result_t ln_q16(logic signed [31:0] x);
        ln_result_t         r;
        logic [63:0]        xr;
        logic [63:0]        q;
        logic [63:0]        rem;
        logic [63:0]        tmag;
        logic [63:0]        pw;
        logic [63:0]        term;
        logic signed [63:0] acc;
        logic signed [63:0] total;
        logic signed [63:0] scaled;
        logic [63:0]        divs;
        bit                 tneg;
        bit                 neg;
        int                 k;
        int                 n;

        r.operand = x;
        if (x < 0) begin
            r.log_value = '0;
            r.status    = ST_NAN;
            return r;
        end
        if (x == 0) begin
            r.log_value = LOG_MIN;
            r.status    = ST_NEG_INF;
            return r;
        end

        xr   = 64'(unsigned'(x)) << 16;
        divs = '0;
        while (xr > TWO_Q32) begin
            q   = xr / E_FIX;
            rem = xr % E_FIX;
            for (k = 0; k < 32; k++) begin
                rem = rem << 1;
                q   = q << 1;
                if (rem >= E_FIX) begin
                    rem  = rem - E_FIX;
                    q[0] = 1'b1;
                end
            end
            xr   = q;
            divs = divs + 1;
        end

        tneg = (xr < ONE_Q32);
        tmag = tneg ? ONE_Q32 - xr : xr - ONE_Q32;
        pw   = ONE_Q32;
        acc  = '0;
        for (n = 1; n <= N_TERMS; n++) begin
            pw   = mul_frac(pw, tmag);
            term = mul_frac(pw, ONE_Q32 / 64'(n));
            neg  = ((n % 2) == 0) != (tneg && ((n % 2) == 1));
            acc  = neg ? acc - signed'(term) : acc + signed'(term);
        end

        total  = signed'(divs << 32) + acc;
        scaled = total >>> 16;
        if (scaled < -64'sd1048576) begin
            r.log_value = LOG_MIN;
        end else if (scaled > 64'sd1048575) begin
            r.log_value = LOG_MAX;
        end else begin
            r.log_value = scaled[20:0];
        end
        r.status = ST_OK;
        return r;
    endfunction

    // sender: bursts of beats separated by random gaps
    always @(posedge i_clk) begin
        logic    nxt_valid;
        int      pick;
        x_beat_t beat;

        nxt_valid = i_in_valid;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                ln_expected.push_back(ln_q16(i_x_value));
                nxt_valid = 1'b0;
                if (burst_left > 0) begin
                    burst_left--;
                end
                if (burst_left == 0) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 4) begin
                        gap_left = 0;
                    end else if (pick < 8) begin
                        gap_left = $urandom_range(1, 20);
                    end else if (pick < 9) begin
                        gap_left = $urandom_range(20, 200);
                    end else begin
                        gap_left = $urandom_range(200, 700);
                    end
                end
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (x_pending.size() > 0 &&
                             !(x_pending[0].hold && ln_expected.size() != 0)) begin
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 10);
                    end
                    beat = x_pending.pop_front();
                    i_x_value <= beat.operand;
                    nxt_valid = 1'b1;
                end
            end
        end
        i_in_valid <= nxt_valid;
    end

    // receiver: ready probability switches between stretches
    always @(posedge i_clk) begin
        int pick;

        if (mode_left == 0) begin
            pick      = $urandom_range(0, 3);
            ready_pct = (pick == 0) ? 100 : (pick == 1) ? 60 : (pick == 2) ? 25 : 5;
            mode_left = $urandom_range(50, 400);
        end else begin
            mode_left--;
        end
        i_out_ready <= ($urandom_range(0, 99) < ready_pct);
    end

    always @(posedge i_clk) begin
        ln_result_t want;

        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (ln_expected.size() == 0) begin
                if (mismatches < MAX_REPORTS) begin
                    $display("unexpected result beat: log_value %0d status %0d",
                             o_log_value, o_status);
                end
                mismatches++;
            end else begin
                want = ln_expected.pop_front();
                if (o_log_value !== want.log_value || o_status !== want.status) begin
                    if (mismatches < MAX_REPORTS) begin
                        $display("mismatch for x 0x%08h: expected %0d/%0d got %0d/%0d",
                                 want.operand, want.log_value, want.status,
                                 o_log_value, o_status);
                    end
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        logic signed [31:0] corner_ops [$];
        x_beat_t            beat;
        int                 pick;
        int                 idx;

        corner_ops = '{
            32'sh0000_0000, 32'sh8000_0000, 32'shFFFF_FFFF, 32'shFFFF_0000,
            32'sh0000_0001, 32'sh0000_0002, 32'sh0000_0100, 32'sh0000_8000,
            32'sh0000_C000, 32'sh0000_FFFF, 32'sh0001_0000, 32'sh0001_0001,
            32'sh0001_8000, 32'sh0001_FFFF, 32'sh0002_0000, 32'sh0002_0001,
            32'sh0002_B7E1, 32'sh0002_B7E2, 32'sh0064_0000, 32'sh4000_0000,
            32'sh7FFF_0000, 32'sh7FFF_FFFF
        };
        foreach (corner_ops[i]) begin
            beat.operand = corner_ops[i];
            beat.hold    = 1'b0;
            x_pending.push_back(beat);
        end

        for (idx = 0; idx < RANDOM_OPS; idx++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                beat.operand = $urandom | 32'h8000_0000;
            end else if (pick < 11) begin
                beat.operand = '0;
            end else if (pick < 25) begin
                beat.operand = $urandom_range(1, 32'h0003_0000);
            end else begin
                beat.operand = $urandom >> $urandom_range(1, 31);
                if (beat.operand == 0) begin
                    beat.operand = 32'sd1;
                end
            end
            // drain point: wait for all outstanding results first
            beat.hold = (idx == 0) || ($urandom_range(0, 199) == 0);
            x_pending.push_back(beat);
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (x_pending.size() != 0 || i_in_valid || ln_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && ln_expected.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* natural_log_series.f */
rtl/core/nls_pkg.sv
rtl/core/nls_div_e.sv
rtl/core/nls_mulq.sv
rtl/core/natural_log_series.sv
rtl/core/nls_checker.sv
bench/natural_log_series_test.sv
